// ===== hdl/ipv6_address_text_compressor_top_macros.svh =====
//------------------------------------------------------------------------------
// IPv6 text compressor assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
//------------------------------------------------------------------------------
`ifndef IPV6_ADDRESS_TEXT_COMPRESSOR_TOP_MACROS_SVH
`define IPV6_ADDRESS_TEXT_COMPRESSOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define IPV6TC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define IPV6TC_ASSERT_IMPL(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define IPV6TC_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define IPV6TC_ASSERT(lbl, clk, rst, prop, msg)
`define IPV6TC_ASSERT_IMPL(lbl, clk, rst, pre, post, msg)
`define IPV6TC_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif

`endif

// ===== hdl/ipv6tc_pkg.sv =====
//------------------------------------------------------------------------------
// IPv6 text compressor package
// Shared constants, the address descriptor type and the hex encoder.
//------------------------------------------------------------------------------
package ipv6tc_pkg;

   localparam int GROUP_COUNT = 8;
   localparam int GROUP_BITS  = 16;
   localparam int HALF_BITS   = 64;
   localparam int CHAR_BITS   = 7;

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_A     = 7'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_COLON = 7'h3A;

   localparam logic [2:0] LAST_GROUP = 3'd7;

   typedef struct packed {
      logic [GROUP_COUNT-1:0][GROUP_BITS-1:0] grp;     // group 0 is most significant
      logic [GROUP_COUNT-1:0][1:0]            nd_m1;   // hex digit count minus one
      logic                                   run;     // a zero run is compressed
      logic [2:0]                             run_lo;
      logic [2:0]                             run_hi;
   } desc_type;

   function automatic logic [CHAR_BITS-1:0] hex_char(input logic [3:0] nib);
      logic [CHAR_BITS-1:0] res;
      if (nib < 4'd10) begin
         res = CHAR_ZERO + {3'b000, nib};
      end else begin
         res = CHAR_A + {3'b000, nib - 4'd10};
      end
      return res;
   endfunction

endpackage

// ===== hdl/ipv6tc_scan.sv =====
//------------------------------------------------------------------------------
// IPv6 text compressor scan pipeline
// Two register stages: zero flags and digit counts, then last zero run search.
//------------------------------------------------------------------------------
module ipv6tc_scan
   import ipv6tc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  logic [HALF_BITS-1:0] in_high,
   input  logic [HALF_BITS-1:0] in_low,
   output logic                 out_valid,
   input  logic                 out_stall,
   output desc_type             out_desc
);

   logic                                   s1_valid_ff, s1_valid_in;
   logic [GROUP_COUNT-1:0][GROUP_BITS-1:0] s1_grp_ff, s1_grp_in;
   logic [GROUP_COUNT-1:0]                 s1_zero_ff, s1_zero_in;
   logic [GROUP_COUNT-1:0][1:0]            s1_nd_ff, s1_nd_in;

   logic     s2_valid_ff, s2_valid_in;
   desc_type s2_desc_ff, s2_desc_in;

   logic                       s1_ready, s2_ready;
   logic [2*HALF_BITS-1:0]     addr;
   logic                       found, broken;
   logic [2:0]                 hi, lo;

   assign s2_ready = !s2_valid_ff || !out_stall;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_stall = !s1_ready;
   assign addr     = {in_high, in_low};

   // stage 1
   always_comb begin
      for (int i = 0; i < GROUP_COUNT; i++) begin
         s1_grp_in[i]  = addr[(GROUP_COUNT-1-i)*GROUP_BITS +: GROUP_BITS];
         s1_zero_in[i] = (s1_grp_in[i] == '0);
         if (s1_grp_in[i][15:12] != 4'd0) begin
            s1_nd_in[i] = 2'd3;
         end else if (s1_grp_in[i][11:8] != 4'd0) begin
            s1_nd_in[i] = 2'd2;
         end else if (s1_grp_in[i][7:4] != 4'd0) begin
            s1_nd_in[i] = 2'd1;
         end else begin
            s1_nd_in[i] = 2'd0;
         end
      end
      s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   end

   // stage 2: last run of two or more zero groups
   always_comb begin
      found = 1'b0;
      hi    = '0;
      for (int i = GROUP_COUNT-1; i >= 1; i--) begin
         if (!found && s1_zero_ff[i] && s1_zero_ff[i-1]) begin
            found = 1'b1;
            hi    = 3'(i);
         end
      end
      lo     = hi;
      broken = 1'b0;
      for (int i = GROUP_COUNT-1; i >= 0; i--) begin
         if (i <= int'(hi)) begin
            if (!broken && s1_zero_ff[i]) begin
               lo = 3'(i);
            end else begin
               broken = 1'b1;
            end
         end
      end
      s2_desc_in.grp    = s1_grp_ff;
      s2_desc_in.nd_m1  = s1_nd_ff;
      s2_desc_in.run    = found;
      s2_desc_in.run_lo = lo;
      s2_desc_in.run_hi = hi;
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_grp_ff  <= s1_grp_in;
         s1_zero_ff <= s1_zero_in;
         s1_nd_ff   <= s1_nd_in;
      end
      if (s2_ready) begin
         s2_desc_ff <= s2_desc_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_desc  = s2_desc_ff;

endmodule

// ===== hdl/ipv6tc_walker.sv =====
//------------------------------------------------------------------------------
// IPv6 text compressor character walker
// Holds one address descriptor and emits its text one character per transfer.
//------------------------------------------------------------------------------
`include "ipv6_address_text_compressor_top_macros.svh"

module ipv6tc_walker
   import ipv6tc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  desc_type             in_desc,
   output logic                 out_valid,
   input  logic                 out_stall,
   output logic [CHAR_BITS-1:0] out_char,
   output logic                 out_last
);

   logic                 w_valid_ff, w_valid_in;
   desc_type             w_desc_ff;
   logic [2:0]           gi_ff, gi_in;
   logic [2:0]           k_ff, k_in;
   logic                 o_valid_ff, o_valid_in;
   logic [CHAR_BITS-1:0] o_char_ff, o_char_in;
   logic                 o_last_ff, o_last_in;

   logic [GROUP_BITS-1:0] cur_grp;
   logic [1:0]            nd_m1, pos;
   logic                  is_lo;
   logic [1:0]            c_cnt;
   logic [2:0]            d_cnt, len;
   logic                  p_cnt;
   logic [3:0]            next_gi;
   logic                  end_grp, last, emit, load, out_free;

   always_comb begin
      cur_grp = w_desc_ff.grp[gi_ff];
      nd_m1   = w_desc_ff.nd_m1[gi_ff];
      is_lo   = w_desc_ff.run && (gi_ff == w_desc_ff.run_lo);
      c_cnt   = is_lo ? ((w_desc_ff.run_lo == 3'd0) ? 2'd2 : 2'd1) : 2'd0;
      d_cnt   = is_lo ? 3'd0 : ({1'b0, nd_m1} + 3'd1);
      p_cnt   = !is_lo && (gi_ff != LAST_GROUP);
      len     = {1'b0, c_cnt} + d_cnt + {2'b00, p_cnt};
      end_grp = (k_ff == len - 3'd1);
      next_gi = is_lo ? ({1'b0, w_desc_ff.run_hi} + 4'd1) : ({1'b0, gi_ff} + 4'd1);
      last    = end_grp && next_gi[3];
      pos     = nd_m1 - k_ff[1:0];

      if (k_ff < {1'b0, c_cnt}) begin
         o_char_in = CHAR_COLON;
      end else if (k_ff < {1'b0, c_cnt} + d_cnt) begin
         o_char_in = hex_char(cur_grp[{pos, 2'b00} +: 4]);
      end else begin
         o_char_in = CHAR_COLON;
      end
      o_last_in = last;

      out_free   = !o_valid_ff || !out_stall;
      emit       = w_valid_ff && out_free;
      load       = !w_valid_ff || (emit && last);
      o_valid_in = out_free ? emit : o_valid_ff;
      w_valid_in = load ? in_valid : w_valid_ff;

      gi_in = gi_ff;
      k_in  = k_ff;
      if (load) begin
         gi_in = '0;
         k_in  = '0;
      end else if (emit) begin
         if (end_grp) begin
            gi_in = next_gi[2:0];
            k_in  = '0;
         end else begin
            k_in  = k_ff + 3'd1;
         end
      end
   end

   assign in_stall = !load;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
         gi_ff      <= '0;
         k_ff       <= '0;
      end else begin
         w_valid_ff <= w_valid_in;
         o_valid_ff <= o_valid_in;
         gi_ff      <= gi_in;
         k_ff       <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         w_desc_ff <= in_desc;
      end
      if (emit) begin
         o_char_ff <= o_char_in;
         o_last_ff <= o_last_in;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_char  = o_char_ff;
   assign out_last  = o_last_ff;

   `IPV6TC_ASSERT_IMPL(a_k_in_group, clock, reset, w_valid_ff, k_ff < len, "char index past group end")
   `IPV6TC_ASSERT_IMPL(a_no_skipped_group, clock, reset, w_valid_ff && w_desc_ff.run, !(gi_ff > w_desc_ff.run_lo && gi_ff <= w_desc_ff.run_hi), "walker on compressed group")
   `IPV6TC_ASSERT_NEXT(a_restart_after_last, clock, reset, emit && last, gi_ff == 3'd0 && k_ff == 3'd0, "walker not rewound after last char")
   `IPV6TC_ASSERT_IMPL(a_hold_when_blocked, clock, reset, w_valid_ff && !out_free, in_stall, "descriptor replaced while output blocked")

endmodule

// ===== hdl/ipv6_address_text_compressor_top.sv =====
//------------------------------------------------------------------------------
// IPv6 address text compressor
// Turns a 128-bit address into its compressed colon-hex text, one ASCII
// character per result transfer, the final character flagged.
//
//   channel | ports                                   | direction
//   req     | req_valid req_stall req_address_high/low | in
//   rsp     | rsp_valid rsp_stall rsp_text_char/last   | out
//
// The first character of an address passes two scan stages, the walker and then
// the output register. Its text then leaves at one character per cycle while
// rsp_stall is low, 2 to 39 characters per address, set by text length.
// Two scan stages buffer addresses behind it.
// Reset is synchronous and clears only valid and walker position state.
// rsp_stall freezes the output and walker; req_stall rises once stages are full.
//------------------------------------------------------------------------------
module ipv6_address_text_compressor_top
   import ipv6tc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [HALF_BITS-1:0] req_address_high,
   input  logic [HALF_BITS-1:0] req_address_low,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CHAR_BITS-1:0] rsp_text_char,
   output logic                 rsp_last_char
);

   logic     scan_valid;
   logic     scan_stall;
   desc_type scan_desc;

   ipv6tc_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_high   (req_address_high),
      .in_low    (req_address_low),
      .out_valid (scan_valid),
      .out_stall (scan_stall),
      .out_desc  (scan_desc)
   );

   ipv6tc_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scan_valid),
      .in_stall  (scan_stall),
      .in_desc   (scan_desc),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_char  (rsp_text_char),
      .out_last  (rsp_last_char)
   );

endmodule
